>>> rtl/lfu_page_replacement_macros.svh
// Assertion macros shared by the LFU page replacement RTL
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lfu_pkg.sv
// Shared constants for the LFU page replacement block
`timescale 1ns / 1ps

package lfu_pkg;

    // Default sizing of the frame table
    localparam int unsigned FRAME_SLOTS_DEF = 8;
    localparam int unsigned PAGE_BITS_DEF   = 16;
    localparam int unsigned COUNT_BITS_DEF  = 16;

    // Fixed port widths
    localparam int unsigned CFG_W        = 4;
    localparam int unsigned PAGE_PORT_W  = 16;
    localparam int unsigned FRAME_PORT_W = 3;
    localparam int unsigned FAULT_W      = 32;

    // Active frame count after reset
    localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd3;

endpackage

>>> rtl/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module lfu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lfu_page_replacement.sv
// Top level: LFU page replacement with a sequential frame scan
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+----------------------------------
//  request   | in        | start, busy               | i_page_number, i_last_access
//  result    | out       | o_result_valid (1 cycle)  | o_hit, o_frame_index, o_evicted_*,
//            |           |                           | o_fault_total, o_run_done
//  config    | in        | i_cfg_we                  | i_cfg_wdata (active frame count)
//
// A transaction runs from accept through the scan state, one frame RAM read per active
// frame, a drain state for the last read data to return, the update state and then the
// result, during which a new start is taken.
// busy is high from the accept edge until the result strobe; the result lasts one cycle.
// Reset is synchronous and active low; all frames come out invalid, the count at 3.
// The receiver cannot stall the result.
`timescale 1ns / 1ps

module lfu_page_replacement #(
    parameter int unsigned FRAME_SLOTS = lfu_pkg::FRAME_SLOTS_DEF,
    parameter int unsigned PAGE_BITS   = lfu_pkg::PAGE_BITS_DEF,
    parameter int unsigned COUNT_BITS  = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic [lfu_pkg::PAGE_PORT_W-1:0]  i_page_number,
    input  logic                             i_last_access,
    output logic                             o_result_valid,
    output logic                             o_hit,
    output logic [lfu_pkg::FRAME_PORT_W-1:0] o_frame_index,
    output logic                             o_evicted_valid,
    output logic [lfu_pkg::PAGE_PORT_W-1:0]  o_evicted_page,
    output logic [lfu_pkg::FAULT_W-1:0]      o_fault_total,
    output logic                             o_run_done
);

    import lfu_pkg::*;

`include "lfu_page_replacement_macros.svh"

    localparam int unsigned IDX_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int unsigned DATA_W = PAGE_BITS + COUNT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_UPDATE
    } t_state;

    t_state r_state;

    // Configuration and request
    logic [CFG_W-1:0]      r_frames;
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_last;
    logic [IDX_W-1:0]      r_last_idx;

    // Scan pointers
    logic [IDX_W-1:0]      r_addr;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;

    // Scan results
    logic                  r_found;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic                  r_have_empty;
    logic [IDX_W-1:0]      r_empty_idx;
    logic [COUNT_BITS-1:0] r_min_cnt;
    logic [IDX_W-1:0]      r_min_idx;
    logic [PAGE_BITS-1:0]  r_min_page;

    // Run state
    logic [FRAME_SLOTS-1:0] r_valid;
    logic [FAULT_W-1:0]     r_fault;

    // Next values
    logic [IDX_W-1:0]      n_last_idx;
    logic [IDX_W-1:0]      n_slot;
    logic [COUNT_BITS-1:0] n_count;
    logic [FAULT_W-1:0]    n_fault;

    // Frame RAM: {page, use count}
    logic                  ram_we;
    logic [DATA_W-1:0]     ram_wdata;
    logic [DATA_W-1:0]     ram_rdata;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  rd_valid;

    lfu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FRAME_SLOTS)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (n_slot),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_page  = ram_rdata[DATA_W-1:COUNT_BITS];
    assign rd_cnt   = ram_rdata[COUNT_BITS-1:0];
    assign rd_valid = r_valid[r_cmp_idx];

    assign busy      = (r_state != S_IDLE);
    assign ram_we    = (r_state == S_UPDATE);
    assign ram_wdata = {r_page, n_count};

    // Last active frame index; zero acts as one, oversize clamps to the table
    always_comb begin
        if (r_frames == '0) begin
            n_last_idx = '0;
        end else if (32'(r_frames) > FRAME_SLOTS) begin
            n_last_idx = IDX_W'(FRAME_SLOTS - 1);
        end else begin
            n_last_idx = IDX_W'(r_frames - 1'b1);
        end
    end

    // Update decision: hit frame, else first empty, else least used
    always_comb begin
        if (r_found) begin
            n_slot  = r_hit_idx;
            n_count = (&r_hit_cnt) ? r_hit_cnt : r_hit_cnt + 1'b1;
        end else begin
            n_slot  = r_have_empty ? r_empty_idx : r_min_idx;
            n_count = COUNT_BITS'(1);
        end
        n_fault = (r_found || (&r_fault)) ? r_fault : r_fault + 1'b1;
    end

    // Sequencer, scan compare and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frames       <= FRAMES_RESET;
            r_cmp_vld      <= 1'b0;
            r_valid        <= '0;
            r_fault        <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;

            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end

            // One frame compared per cycle as its RAM word returns
            if (r_cmp_vld) begin
                if (!r_found && rd_valid && (rd_page == r_page)) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_hit_cnt <= rd_cnt;
                end
                if (!r_have_empty && !rd_valid) begin
                    r_have_empty <= 1'b1;
                    r_empty_idx  <= r_cmp_idx;
                end
                if (rd_valid && ((r_cmp_idx == '0) || (rd_cnt < r_min_cnt))) begin
                    r_min_cnt  <= rd_cnt;
                    r_min_idx  <= r_cmp_idx;
                    r_min_page <= rd_page;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (start) begin
                        r_page       <= PAGE_BITS'(i_page_number);
                        r_last       <= i_last_access;
                        r_last_idx   <= n_last_idx;
                        r_addr       <= '0;
                        r_found      <= 1'b0;
                        r_have_empty <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_addr;
                    if (r_addr == r_last_idx) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= S_UPDATE;
                end
                S_UPDATE: begin
                    o_result_valid  <= 1'b1;
                    o_hit           <= r_found;
                    o_frame_index   <= FRAME_PORT_W'(n_slot);
                    o_evicted_valid <= !r_found && !r_have_empty;
                    o_evicted_page  <= (!r_found && !r_have_empty)
                                       ? PAGE_PORT_W'(r_min_page) : '0;
                    o_fault_total   <= n_fault;
                    o_run_done      <= r_last;
                    // End of run clears frames and the fault total
                    if (r_last) begin
                        r_valid <= '0;
                        r_fault <= '0;
                    end else begin
                        r_valid[n_slot] <= 1'b1;
                        r_fault         <= n_fault;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `LFU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "busy low after accept")
    `LFU_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_result_valid, !busy,
        "result while busy")
    `LFU_ASSERT_NOW(a_hit_no_evict, i_clk, i_rst_n, o_result_valid && o_hit,
        !o_evicted_valid && (o_evicted_page == '0), "eviction on hit")
    `LFU_ASSERT_NOW(a_miss_counted, i_clk, i_rst_n, o_result_valid && !o_hit,
        o_fault_total != '0, "miss not counted")
    `LFU_ASSERT_NOW(a_run_cleared, i_clk, i_rst_n, o_result_valid && o_run_done,
        (r_fault == '0) && (r_valid == '0), "run state not cleared")

endmodule
